FILE: hw/rtl/random_byte_to_charset_sampler_top_assert.svh
// Assertion macros shared by the sampler RTL.
// Each expects clk and rst_n in scope.
`ifndef RANDOM_BYTE_TO_CHARSET_SAMPLER_TOP_ASSERT_SVH
`define RANDOM_BYTE_TO_CHARSET_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RBCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RBCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rbcs_pkg.sv
package rbcs_pkg;

  typedef struct packed {
    logic [7:0] random_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_of_run;
    logic       password_done;
  } out_item_t;

  // Up to two characters per input transaction
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } res_bundle_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED_SETS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSWORD_LENGTH = 1'b1;

  localparam logic [3:0] SETS_RESET   = 4'd15;
  localparam logic [7:0] LENGTH_RESET = 8'd16;

  localparam logic [6:0] DIGIT_CNT   = 7'd10;
  localparam logic [6:0] ALPHA_CNT   = 7'd26;
  localparam logic [6:0] SPECIAL_CNT = 7'd14;

  localparam logic [7:0] DIGIT_BASE = 8'h30;  // '0'
  localparam logic [7:0] LOWER_BASE = 8'h61;  // 'a'
  localparam logic [7:0] UPPER_BASE = 8'h41;  // 'A'
  localparam logic [7:0] QMARK      = 8'h3F;  // '?'

  // !@#$%^&*()-_=+
  localparam logic [7:0] SPECIALS [14] = '{
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26,
    8'h2A, 8'h28, 8'h29, 8'h2D, 8'h5F, 8'h3D, 8'h2B
  };

  function automatic logic [6:0] alpha_size(input logic [3:0] sets);
    logic [6:0] s;
    s = '0;
    if (sets[0]) s = s + DIGIT_CNT;
    if (sets[1]) s = s + ALPHA_CNT;
    if (sets[2]) s = s + ALPHA_CNT;
    if (sets[3]) s = s + SPECIAL_CNT;
    return s;
  endfunction

  // Bits per draw: smallest b with 2^b >= size (size is 10..76 when non-zero)
  function automatic logic [2:0] draw_width(input logic [6:0] size);
    logic [2:0] w;
    if (size <= 7'd16) w = 3'd4;
    else if (size <= 7'd32) w = 3'd5;
    else if (size <= 7'd64) w = 3'd6;
    else w = 3'd7;
    return w;
  endfunction

  function automatic logic [7:0] pick_char(input logic [3:0] sets, input logic [6:0] pos);
    logic [6:0] p;
    logic [7:0] ch;
    logic       hit;
    p   = pos;
    ch  = QMARK;
    hit = 1'b0;
    if (sets[0]) begin
      if (p < DIGIT_CNT) begin
        ch  = DIGIT_BASE + {1'b0, p};
        hit = 1'b1;
      end else begin
        p = p - DIGIT_CNT;
      end
    end
    if (sets[1] && !hit) begin
      if (p < ALPHA_CNT) begin
        ch  = LOWER_BASE + {1'b0, p};
        hit = 1'b1;
      end else begin
        p = p - ALPHA_CNT;
      end
    end
    if (sets[2] && !hit) begin
      if (p < ALPHA_CNT) begin
        ch  = UPPER_BASE + {1'b0, p};
        hit = 1'b1;
      end else begin
        p = p - ALPHA_CNT;
      end
    end
    if (sets[3] && !hit && (p < SPECIAL_CNT)) begin
      ch = SPECIALS[p[3:0]];
    end
    return ch;
  endfunction

endpackage

FILE: hw/rtl/random_byte_to_charset_sampler_top.sv
// Random byte to password character sampler. Each random byte on the input
// channel is appended above the bits left over from earlier bytes; draws of
// 4 to 7 bits (enough to index the alphabet of enabled sets: digits, lower
// case, upper case, specials) are taken from the bottom, out-of-range draws
// are dropped and the rest become ASCII characters, at most two per byte.
// Characters stop once password_length (saturated at MAX_LENGTH) have been
// produced; a transaction with restart set begins a new password. A byte is
// registered on acceptance and turned into its characters in one pass once
// the result buffer has room; the characters are then registered there.
// Throughput is one input transaction per cycle while bytes yield at most one
// character and out_ready is high; a byte yielding two holds the next back
// until one of them has left the two-slot result buffer by the single output port.
// Configuration writes take effect at once; writing enabled_sets drops any
// held bits. Write only while the block is idle.

`include "random_byte_to_charset_sampler_top_assert.svh"

module random_byte_to_charset_sampler_top #(
  parameter int unsigned MAX_LENGTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rbcs_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rbcs_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [rbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [7:0] MAX_LEN_C = 8'(MAX_LENGTH);

  // configuration registers
  logic [3:0] sets_r, sets_nxt;
  logic [7:0] len_r, len_nxt;
  logic       sets_wr;
  logic [7:0] eff_len;

  // input register
  rbcs_pkg::in_item_t in_r, in_nxt;
  logic               in_vld_r, in_vld_nxt;

  logic                  can_take;
  logic                  proc_fire;
  logic                  in_accept;
  rbcs_pkg::res_bundle_t res;

  always_comb begin
    sets_nxt = sets_r;
    len_nxt  = len_r;
    sets_wr  = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        rbcs_pkg::CFG_ENABLED_SETS: begin
          sets_nxt = cfg_wdata[3:0];
          sets_wr  = 1'b1;
        end
        rbcs_pkg::CFG_PASSWORD_LENGTH: begin
          len_nxt = cfg_wdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign eff_len = (len_r > MAX_LEN_C) ? MAX_LEN_C : len_r;

  // Input stage: the held byte moves on as soon as the result buffer has room
  assign proc_fire = in_vld_r && can_take;
  assign in_ready  = !in_vld_r || can_take;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    in_nxt     = in_r;
    in_vld_nxt = in_vld_r;
    if (proc_fire) begin
      in_vld_nxt = 1'b0;
    end
    if (in_accept) begin
      in_nxt     = in_data;
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sets_r   <= rbcs_pkg::SETS_RESET;
      len_r    <= rbcs_pkg::LENGTH_RESET;
      in_vld_r <= 1'b0;
    end else begin
      sets_r   <= sets_nxt;
      len_r    <= len_nxt;
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
  end

  rbcs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .sets    (sets_r),
    .eff_len (eff_len),
    .sets_wr (sets_wr),
    .fire    (proc_fire),
    .item    (in_r),
    .res     (res)
  );

  rbcs_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc_fire),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `RBCS_ASSERT_NXT(a_fire_drains, proc_fire && !in_accept, !in_vld_r,
                   "input register not freed after transaction moved on")

endmodule

FILE: hw/rtl/rbcs_core.sv
`include "random_byte_to_charset_sampler_top_assert.svh"

module rbcs_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [3:0]           sets,
  input  logic [7:0]           eff_len,
  input  logic                 sets_wr,
  input  logic                 fire,
  input  rbcs_pkg::in_item_t   item,
  output rbcs_pkg::res_bundle_t res
);

  logic [6:0] pool_r, pool_nxt;
  logic [2:0] held_r, held_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  logic [6:0]  pool_v;
  logic [2:0]  held_v;
  logic [7:0]  cnt_v;
  logic [6:0]  size;
  logic [2:0]  w;
  logic [3:0]  w2;
  logic        idle;
  logic [14:0] acc, sh1, sh2;
  logic [6:0]  mask7, d0, d1;
  logic [3:0]  avail, left;
  logic        two, ok0, ok1, emit1, done0, done1;
  logic [7:0]  cnt1;
  logic [1:0]  nres;
  logic [7:0]  c0, c1;

  always_comb begin
    pool_v = item.restart ? '0 : pool_r;
    held_v = item.restart ? '0 : held_r;
    cnt_v  = item.restart ? '0 : cnt_r;

    size = rbcs_pkg::alpha_size(sets);
    w    = rbcs_pkg::draw_width(size);
    w2   = {w, 1'b0};
    idle = (size == '0) || (cnt_v >= eff_len);

    acc   = {8'b0, pool_v} | ({7'b0, item.random_byte} << held_v);
    mask7 = 7'h7F >> (3'd7 - w);
    sh1   = acc >> w;
    sh2   = acc >> w2;
    d0    = acc[6:0] & mask7;
    d1    = sh1[6:0] & mask7;
    avail = {1'b0, held_v} + 4'd8;
    two   = avail >= w2;
    left  = two ? (avail - w2) : (avail - {1'b0, w});

    ok0   = !idle && (d0 < size);
    ok1   = !idle && two && (d1 < size);
    done0 = ok0 && (({1'b0, cnt_v} + 9'd1) >= {1'b0, eff_len});
    cnt1  = cnt_v + {7'b0, ok0};
    emit1 = ok1 && !done0;
    done1 = emit1 && (({1'b0, cnt1} + 9'd1) >= {1'b0, eff_len});
    nres  = {1'b0, ok0} + {1'b0, emit1};

    c0 = rbcs_pkg::pick_char(sets, d0);
    c1 = rbcs_pkg::pick_char(sets, d1);
  end

  always_comb begin
    res.cnt                 = nres;
    res.item0.character     = ok0 ? c0 : c1;
    res.item0.password_done = ok0 ? done0 : done1;
    res.item0.last_of_run   = (nres == 2'd1);
    res.item1.character     = c1;
    res.item1.password_done = done1;
    res.item1.last_of_run   = 1'b1;
  end

  always_comb begin
    pool_nxt = pool_r;
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    if (fire) begin
      cnt_nxt = cnt_v + {6'b0, nres};
      if (idle || done0 || done1) begin
        pool_nxt = '0;
        held_nxt = '0;
      end else begin
        pool_nxt = two ? sh2[6:0] : sh1[6:0];
        held_nxt = left[2:0];
      end
    end
    // new alphabet: stale bits are of the wrong width
    if (sets_wr) begin
      pool_nxt = '0;
      held_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= '0;
      held_r <= '0;
      cnt_r  <= '0;
    end else begin
      pool_r <= pool_nxt;
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `RBCS_ASSERT_IMP(a_held_below_width, 1'b1, held_r < w, "held bits reach draw width")
  `RBCS_ASSERT_IMP(a_pool_clean, 1'b1, (pool_r >> held_r) == 7'd0, "pool bits above held count")
  `RBCS_ASSERT_NXT(a_done_at_len, fire && (done0 || done1), cnt_r == $past(eff_len),
                   "password done with count not at length")

endmodule

FILE: hw/rtl/rbcs_res_buf.sv
`include "random_byte_to_charset_sampler_top_assert.svh"

module rbcs_res_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  rbcs_pkg::res_bundle_t res,
  output logic                  can_take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rbcs_pkg::out_item_t   out_data
);

  rbcs_pkg::out_item_t slot0_r, slot0_nxt;
  rbcs_pkg::out_item_t slot1_r, slot1_nxt;
  logic [1:0]          cnt_r, cnt_nxt;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  // room once whatever is left drains this cycle
  assign can_take  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (out_valid && out_ready) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
    if (load) begin
      slot0_nxt = res.item0;
      slot1_nxt = res.item1;
      cnt_nxt   = res.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  `RBCS_ASSERT_IMP(a_fill_range, 1'b1, cnt_r != 2'd3, "result buffer overfilled")

endmodule

FILE: test/tb_top.sv
module tb_top;

  // Block parameter, kept equal to the instance below
  localparam int unsigned MAX_LEN = 128;
  // Cycles to let pass after the last transaction before the block counts as idle
  localparam int SETTLE = 8;
  localparam int LONG_STALL = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_TARGET = 1850;
  localparam int PHASE_ITEMS = 120;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  rbcs_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rbcs_pkg::out_item_t  out_data;
  logic                 cfg_we = 1'b0;
  logic [rbcs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rbcs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  random_byte_to_charset_sampler_top #(.MAX_LENGTH(MAX_LEN)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Bytes waiting to be offered, and characters the block owes us
  rbcs_pkg::in_item_t  byte_queue[$];
  rbcs_pkg::out_item_t expected_chars[$];

  // Handshake pacing, set by the sequencing block
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          send_pause = 1'b0;
  int          stall_req = 0;
  int          stall_served = 0;
  bit          stall_on = 1'b0;

  bit                  in_taken = 1'b0;
  int                  err_count = 0;
  int                  cycle_count = 0;
  int                  items_sent = 0;
  rbcs_pkg::out_item_t want_char;

  // Shadow copy of the sampler: registers, pool and progress through the password
  logic [3:0]  sets_q = rbcs_pkg::SETS_RESET;
  logic [7:0]  length_q = rbcs_pkg::LENGTH_RESET;
  logic [6:0]  pool_q = '0;
  logic [2:0]  held_q = '0;
  logic [7:0]  count_q = '0;
  string       alphabet;

  initial begin
    forever #1 clk = ~clk;
  end

  // Alphabet as the enabled sets joined in fixed order
  function automatic string build_alphabet(logic [3:0] s);
    string a;
    a = "";
    if (s[0]) a = {a, "0123456789"};
    if (s[1]) a = {a, "abcdefghijklmnopqrstuvwxyz"};
    if (s[2]) a = {a, "ABCDEFGHIJKLMNOPQRSTUVWXYZ"};
    if (s[3]) a = {a, "!@#$%^&*()-_=+"};
    return a;
  endfunction

  function automatic int unsigned target_len(logic [7:0] l);
    return (l > MAX_LEN) ? MAX_LEN : l;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (err_count < 40)
      $display("MISMATCH %s: got 0x%0h, want 0x%0h (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  // Work out the characters one accepted byte yields, oldest first
  task automatic predict_chars(rbcs_pkg::in_item_t it);
    int unsigned         size, lim, width, acc, avail, mask, val, n;
    bit                  done;
    rbcs_pkg::out_item_t res [2];
    if (it.restart) begin
      pool_q = '0;
      held_q = '0;
      count_q = '0;
    end
    size = alphabet.len();
    lim = target_len(length_q);
    // no set enabled, or password already complete: byte dropped
    if (size == 0 || count_q >= lim) begin
      pool_q = '0;
      held_q = '0;
      return;
    end
    width = 0;
    while ((1 << width) < size) width++;
    acc = pool_q | (32'(it.random_byte) << held_q);
    avail = held_q + 8;
    mask = (1 << width) - 1;
    n = 0;
    done = 1'b0;
    while (avail >= width && n < 2 && !done) begin
      val = acc & mask;
      acc = acc >> width;
      avail = avail - width;
      if (val < size) begin
        count_q = count_q + 8'd1;
        done = (count_q >= lim);
        res[n].character = alphabet[val];
        res[n].last_of_run = 1'b0;
        res[n].password_done = done;
        n++;
      end
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_chars.push_back(res[i]);
    if (done) begin
      pool_q = '0;
      held_q = '0;
    end else begin
      pool_q = acc[6:0];
      held_q = avail[2:0];
    end
  endtask

  // Input side: register writes and accepted transactions feed the shadow model
  always @(posedge clk) begin
    cycle_count++;
    in_taken = in_valid && in_ready;
    if (!rst_n) begin
      sets_q = rbcs_pkg::SETS_RESET;
      length_q = rbcs_pkg::LENGTH_RESET;
      pool_q = '0;
      held_q = '0;
      count_q = '0;
      alphabet = build_alphabet(rbcs_pkg::SETS_RESET);
    end else begin
      if (cfg_we) begin
        if (cfg_index == rbcs_pkg::CFG_ENABLED_SETS) begin
          sets_q = cfg_wdata[3:0];
          alphabet = build_alphabet(sets_q);
          pool_q = '0;
          held_q = '0;
        end else if (cfg_index == rbcs_pkg::CFG_PASSWORD_LENGTH) begin
          length_q = cfg_wdata;
        end
      end
      if (in_taken) predict_chars(in_data);
    end
  end

  // Output side: each transaction against the oldest outstanding character
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", out_data.character, 0);
      end else begin
        want_char = expected_chars.pop_front();
        if (out_data.character !== want_char.character)
          report_mismatch("character", out_data.character, want_char.character);
        if (out_data.last_of_run !== want_char.last_of_run)
          report_mismatch("last_of_run", out_data.last_of_run, want_char.last_of_run);
        if (out_data.password_done !== want_char.password_done)
          report_mismatch("password_done", out_data.password_done, want_char.password_done);
      end
    end
  end

  // Driver: valid stays up with a steady payload until the transaction is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (byte_queue.size() != 0 && !send_pause &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data <= byte_queue.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && !stall_on && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off, timed here so that the sender keeps pushing meanwhile
  initial begin
    forever begin
      @(posedge clk);
      if (stall_served != stall_req) begin
        stall_served = stall_req;
        stall_on = 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        stall_on = 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d characters outstanding",
             cycle_count, expected_chars.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_item(logic [7:0] b, logic r);
    rbcs_pkg::in_item_t it;
    it.random_byte = b;
    it.restart = r;
    byte_queue.push_back(it);
    items_sent++;
  endtask

  task automatic cfg_write(logic [rbcs_pkg::CFG_IDX_W-1:0] idx,
                           logic [rbcs_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Everything offered, taken and answered, plus slack for a byte still in flight
  task automatic drain;
    while (byte_queue.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int unsigned corner_len(int k);
    case (k)
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 16;
      4: return 17;
      5: return 128;
      6: return 129;
      default: return 255;
    endcase
  endfunction

  initial begin
    int          phase_no;
    int          start_sent;
    int          progress;
    int          n_items;
    int unsigned sets_v, len_v, lim;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed part ---
    send_idle_pct = 21;
    recv_idle_pct = 58;

    // reset settings: all four sets, length 16, byte extremes
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'hFE, 1'b0);
    push_item(8'h55, 1'b0);
    push_item(8'hAA, 1'b0);
    drain();

    // no set enabled: bytes dropped
    cfg_write(rbcs_pkg::CFG_ENABLED_SETS, 8'hF0);
    push_item(8'h3C, 1'b1);
    push_item(8'hC3, 1'b0);
    drain();

    // zero length: nothing produced even with a live alphabet
    cfg_write(rbcs_pkg::CFG_ENABLED_SETS, 8'h01);
    cfg_write(rbcs_pkg::CFG_PASSWORD_LENGTH, 8'h00);
    push_item(8'h12, 1'b1);
    push_item(8'h34, 1'b0);
    drain();

    // one-character password from specials; the next byte is dropped until a restart
    cfg_write(rbcs_pkg::CFG_ENABLED_SETS, 8'h08);
    cfg_write(rbcs_pkg::CFG_PASSWORD_LENGTH, 8'h01);
    push_item(8'h00, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h0D, 1'b1);
    drain();

    // lower case only, a few characters in, then length cut below the count
    cfg_write(rbcs_pkg::CFG_ENABLED_SETS, 8'h02);
    cfg_write(rbcs_pkg::CFG_PASSWORD_LENGTH, 8'd16);
    push_item(8'h00, 1'b1);
    push_item(8'h21, 1'b0);
    push_item(8'h42, 1'b0);
    push_item(8'hFF, 1'b0);
    drain();
    cfg_write(rbcs_pkg::CFG_PASSWORD_LENGTH, 8'd2);
    push_item(8'h11, 1'b0);
    push_item(8'h11, 1'b1);
    drain();

    // --- random part: new settings per phase, pacing changes with progress ---
    phase_no = 0;
    start_sent = items_sent;
    while (items_sent - start_sent < RANDOM_TARGET) begin
      progress = items_sent - start_sent;
      if (progress < RANDOM_TARGET / 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 58;
      end else if (progress < 2 * RANDOM_TARGET / 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (phase_no % 8)
        0: sets_v = 15;
        1: sets_v = 1;
        3: sets_v = 8;
        5: sets_v = 4;
        default: sets_v = $urandom_range(15);
      endcase
      if ($urandom_range(9) < 4) len_v = corner_len($urandom_range(7));
      else len_v = $urandom_range(128, 16);
      lim = target_len(8'(len_v));

      // the sets register is always rewritten; length sometimes kept from before
      cfg_write(rbcs_pkg::CFG_ENABLED_SETS, {4'($urandom_range(15)), 4'(sets_v)});
      if (phase_no < 4 || $urandom_range(3) != 0)
        cfg_write(rbcs_pkg::CFG_PASSWORD_LENGTH, 8'(len_v));

      // last phase only tops up to the target
      n_items = RANDOM_TARGET - progress;
      if (n_items > PHASE_ITEMS) n_items = PHASE_ITEMS;
      for (int i = 0; i < n_items; i++) begin
        if (i == 0) push_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        else push_item(8'($urandom_range(255)), 1'($urandom_range(lim + 3) == 0));
      end

      // fill the block: long receiver hold-off while bytes keep coming
      if (phase_no == 1 || phase_no == 6) stall_req++;

      // sender stops mid-phase until every owed character has arrived
      if (phase_no % 3 == 2) begin
        while (byte_queue.size() > PHASE_ITEMS / 2) @(posedge clk);
        send_pause = 1'b1;
        while (in_valid || expected_chars.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        send_pause = 1'b0;
      end

      drain();
      phase_no++;
    end

    drain();
    if (expected_chars.size() != 0)
      report_mismatch("characters never produced", 0, expected_chars.size());
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
